FILE: design/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rau_pkg.sv
// Package of the rational arithmetic unit: sizes, codes, state and ALU types.
`default_nettype none
package rau_pkg;

  localparam int WORD_BITS = 64;
  localparam int WIDE_BITS = 2 * WORD_BITS;
  localparam int DEN_BITS  = 63;
  localparam int MUL_STEPS = 64;
  localparam int DIV_STEPS = WIDE_BITS;
  localparam int POW_BITS  = 16;
  localparam logic [63:0] NUM_MAX = (64'd1 << (WORD_BITS - 1)) - 64'd1;

  typedef enum logic [3:0] {
    FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_NEG, FN_POW,
    FN_EQ, FN_NE, FN_LT, FN_LE, FN_GT, FN_GE
  } func_t;

  typedef enum logic [1:0] {
    ST_OK, ST_OVERFLOW, ST_DIV_ZERO
  } status_t;

  typedef enum logic {
    ALU_ADD, ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic carry;  // carry out; for a subtract, set when there is no borrow
    logic zero;
  } alu_flags_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_MSTART, S_MUL, S_MDONE, S_ADD, S_ADD2, S_CMP,
    S_FIN, S_GSH, S_GA, S_GB, S_GC1, S_GC2, S_GK, S_DIV, S_DDONE,
    S_RANGE, S_PSTEP, S_PEND, S_EMIT
  } state_t;

endpackage
`default_nettype wire

FILE: design/rau_addsub.sv
// Shared wide adder/subtractor with carry and zero flags.
`default_nettype none
module rau_addsub import rau_pkg::*; (
  input  logic [WIDE_BITS-1:0] a,
  input  logic [WIDE_BITS-1:0] b,
  input  alu_op_t              op,
  output logic [WIDE_BITS-1:0] sum,
  output alu_flags_t           flags
);

  logic [WIDE_BITS:0]   full;
  logic [WIDE_BITS-1:0] b_in;

  assign b_in = (op == ALU_SUB) ? ~b : b;
  assign full = {1'b0, a} + {1'b0, b_in} + {{WIDE_BITS{1'b0}}, (op == ALU_SUB)};
  assign sum  = full[WIDE_BITS-1:0];
  assign flags.carry = full[WIDE_BITS];
  assign flags.zero  = (full[WIDE_BITS-1:0] == '0);

endmodule
`default_nettype wire

FILE: design/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: sequencer and datapath.
// Exact arithmetic on two fractions a = a_num/a_den and b = b_num/b_den.
// Input channel in_*: one request per accepted beat. in_tuser carries func
// (add, sub, mul, div, neg, pow, eq, ne, lt, le, gt, ge); in_tdata carries
// a_num, a_den, b_num, b_den. For pow the low 16 bits of b_num are the
// exponent. Result channel out_*: one result per request, res_num/res_den
// reduced by the gcd with a positive denominator, compare_true for the
// comparisons, and status (ok, overflow, division by zero) in out_tuser.
// All work runs through one 128-bit adder/subtractor: products are formed
// shift-and-add, the gcd is binary (one shift, compare or subtract a cycle),
// and the reduction divides bit by bit. Unused codes and zero denominators
// go straight to the result; comparisons form two products, mul and div two
// and add and sub three before the gcd reduction, neg is reduced directly,
// and the gcd takes as long as the data needs; pow reduces its base, then
// runs 16 rounds of two to four products, squaring the base in each round.
// in_tready is high only while the sequencer is idle; one request at a time.
// The result register parts the two sides: a new request is taken while the
// previous result still waits, and a finished result holds in a staging
// register until the output register is free. Reset (rst_n low at a clock
// edge) drops any request in flight and empties the output register.
`default_nettype none
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [255:0] in_tdata,   // a_num[63:0], a_den[126:64], b_num[190:127],
                                   // b_den[253:191], zero pad[255:254]
  input  logic [3:0]   in_tuser,   // func[3:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // res_num[63:0], res_den[126:64], compare_true[127]
  output logic [1:0]   out_tuser   // status[1:0]
);

  // Control state
  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Captured request
  logic [3:0]          f_r, f_nxt;
  logic [63:0]         an_r, an_nxt, bn_r, bn_nxt;
  logic [DEN_BITS-1:0] ad_r, ad_nxt, bd_r, bd_nxt;

  // Working registers
  logic [WIDE_BITS-1:0] xa_r, xa_nxt, xb_r, xb_nxt, xc_r, xc_nxt;
  logic [WIDE_BITS-1:0] acc_r, acc_nxt, mc_r, mc_nxt;
  logic [63:0]          mp_r, mp_nxt;
  logic [WIDE_BITS-1:0] ga_r, ga_nxt, gb_r, gb_nxt;
  logic [WIDE_BITS-1:0] dv_r, dv_nxt, rm_r, rm_nxt;
  logic [6:0]           cnt_r, cnt_nxt, k_r, k_nxt;
  logic [1:0]           ph_r, ph_nxt;
  logic                 dph_r, dph_nxt, neg_r, neg_nxt;
  logic [3:0]           pi_r, pi_nxt;
  logic [63:0]          prn_r, prn_nxt, prd_r, prd_nxt, pbn_r, pbn_nxt, pbd_r, pbd_nxt;

  // Staged and presented result
  logic [63:0]          em_num_r, em_num_nxt, out_num_r, out_num_nxt;
  logic [DEN_BITS-1:0]  em_den_r, em_den_nxt, out_den_r, out_den_nxt;
  logic                 em_cmp_r, em_cmp_nxt, out_cmp_r, out_cmp_nxt;
  status_t              em_st_r, em_st_nxt, out_st_r, out_st_nxt;

  // Shared unit
  logic [WIDE_BITS-1:0] alu_a, alu_b, alu_sum;
  alu_op_t              alu_op;
  alu_flags_t           alu_flags;

  // Derived values
  logic                 sa, sb, uses_b, s2;
  logic [63:0]          ma, mb, ad64, bd64, mul_x, mul_y, plim, capped, cap_lim;
  logic [POW_BITS-1:0]  expo;
  logic [WIDE_BITS-1:0] rm_sh;
  logic                 ln, rneg, c_lt, c_gt, c_eq, t_cmp, ovf;

  rau_addsub u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .op    (alu_op),
    .sum   (alu_sum),
    .flags (alu_flags)
  );

  assign sa     = an_r[63];
  assign sb     = bn_r[63];
  assign ma     = sa ? (64'd0 - an_r) : an_r;
  assign mb     = sb ? (64'd0 - bn_r) : bn_r;
  assign ad64   = {1'b0, ad_r};
  assign bd64   = {1'b0, bd_r};
  assign uses_b = (f_r != FN_NEG) && (f_r != FN_POW);
  assign s2     = (f_r == FN_SUB) ? ~sb : sb;
  assign expo   = bn_r[POW_BITS-1:0];
  assign plim   = neg_r ? (NUM_MAX + 64'd1) : NUM_MAX;
  assign rm_sh  = {rm_r[WIDE_BITS-2:0], dv_r[WIDE_BITS-1]};

  // Operand selection for the shift-add multiplier.
  always_comb begin
    mul_x = ma;
    mul_y = bd64;
    if (f_r == FN_POW) begin
      unique case (ph_r)
        2'd0: begin mul_x = prn_r; mul_y = pbn_r; end
        2'd1: begin mul_x = prd_r; mul_y = pbd_r; end
        2'd2: begin mul_x = pbn_r; mul_y = pbn_r; end
        2'd3: begin mul_x = pbd_r; mul_y = pbd_r; end
      endcase
    end else begin
      unique case (ph_r)
        2'd0: begin
          mul_x = ma;
          mul_y = (f_r == FN_MUL) ? mb : bd64;
        end
        2'd1: begin
          priority if (f_r == FN_MUL) begin
            mul_x = ad64; mul_y = bd64;
          end else if (f_r == FN_DIV) begin
            mul_x = ad64; mul_y = mb;
          end else begin
            mul_x = mb; mul_y = ad64;
          end
        end
        2'd2, 2'd3: begin mul_x = ad64; mul_y = bd64; end
      endcase
    end
  end

  // Saturate a power-step product above its limit.
  assign cap_lim = ph_r[0] ? NUM_MAX : plim;
  assign capped  = ((acc_r[WIDE_BITS-1:64] != '0) || (acc_r[63:0] > cap_lim)) ?
                   '1 : acc_r[63:0];

  // Range check of the reduced fraction.
  assign ovf = (xa_r[WIDE_BITS-1:64] != '0) || (xb_r[WIDE_BITS-1:64] != '0) ||
               (xa_r[63:0] > plim) || (xb_r[63:0] > NUM_MAX);

  // Signed compare from the magnitude compare l - r.
  always_comb begin
    ln   = sa && (xa_r != '0);
    rneg = sb && (xc_r != '0);
    priority if (ln != rneg) begin
      c_lt = ln; c_gt = ~ln; c_eq = 1'b0;
    end else if (ln) begin
      c_lt = alu_flags.carry && !alu_flags.zero;
      c_gt = !alu_flags.carry;
      c_eq = alu_flags.zero;
    end else begin
      c_lt = !alu_flags.carry;
      c_gt = alu_flags.carry && !alu_flags.zero;
      c_eq = alu_flags.zero;
    end
    unique case (f_r)
      FN_EQ:   t_cmp = c_eq;
      FN_NE:   t_cmp = !c_eq;
      FN_LT:   t_cmp = c_lt;
      FN_LE:   t_cmp = c_lt || c_eq;
      FN_GT:   t_cmp = c_gt;
      default: t_cmp = c_gt || c_eq;
    endcase
  end

  // Sequencer: next state, shared-unit control and datapath updates.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    f_nxt = f_r; an_nxt = an_r; ad_nxt = ad_r; bn_nxt = bn_r; bd_nxt = bd_r;
    xa_nxt = xa_r; xb_nxt = xb_r; xc_nxt = xc_r;
    acc_nxt = acc_r; mc_nxt = mc_r; mp_nxt = mp_r;
    ga_nxt = ga_r; gb_nxt = gb_r; dv_nxt = dv_r; rm_nxt = rm_r;
    cnt_nxt = cnt_r; k_nxt = k_r; ph_nxt = ph_r; dph_nxt = dph_r; neg_nxt = neg_r;
    pi_nxt = pi_r; prn_nxt = prn_r; prd_nxt = prd_r; pbn_nxt = pbn_r; pbd_nxt = pbd_r;
    em_num_nxt = em_num_r; em_den_nxt = em_den_r; em_cmp_nxt = em_cmp_r;
    em_st_nxt = em_st_r;
    out_num_nxt = out_num_r; out_den_nxt = out_den_r; out_cmp_nxt = out_cmp_r;
    out_st_nxt = out_st_r;
    alu_a  = '0;
    alu_b  = '0;
    alu_op = ALU_ADD;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          f_nxt  = in_tuser;
          an_nxt = in_tdata[63:0];
          ad_nxt = in_tdata[126:64];
          bn_nxt = in_tdata[190:127];
          bd_nxt = in_tdata[253:191];
          state_nxt = S_LOAD;
        end
      end

      S_LOAD: begin
        em_num_nxt = '0;
        em_den_nxt = DEN_BITS'(1);
        em_cmp_nxt = 1'b0;
        em_st_nxt  = ST_OK;
        priority if (f_r > FN_GE) begin
          state_nxt = S_EMIT;
        end else if ((ad_r == '0) || (uses_b && (bd_r == '0))) begin
          em_st_nxt = ST_DIV_ZERO;
          state_nxt = S_EMIT;
        end else if ((f_r == FN_DIV) && (mb == '0)) begin
          em_st_nxt = ST_DIV_ZERO;
          state_nxt = S_EMIT;
        end else if (f_r == FN_NEG) begin
          xa_nxt    = {64'd0, ma};
          xb_nxt    = {64'd0, ad64};
          neg_nxt   = ~sa;
          state_nxt = S_FIN;
        end else if (f_r == FN_POW) begin
          if (ma == '0) begin
            em_num_nxt = (expo == '0) ? 64'd1 : 64'd0;
            state_nxt  = S_EMIT;
          end else begin
            xa_nxt    = {64'd0, ma};
            xb_nxt    = {64'd0, ad64};
            state_nxt = S_FIN;
          end
        end else begin
          ph_nxt    = 2'd0;
          state_nxt = S_MSTART;
        end
      end

      S_MSTART: begin
        acc_nxt   = '0;
        mc_nxt    = {64'd0, mul_x};
        mp_nxt    = mul_y;
        cnt_nxt   = '0;
        state_nxt = S_MUL;
      end

      S_MUL: begin
        alu_a = acc_r;
        alu_b = mc_r;
        if (mp_r[0]) acc_nxt = alu_sum;
        mc_nxt  = {mc_r[WIDE_BITS-2:0], 1'b0};
        mp_nxt  = {1'b0, mp_r[63:1]};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(MUL_STEPS - 1)) state_nxt = S_MDONE;
      end

      S_MDONE: begin
        if (f_r == FN_POW) begin
          unique case (ph_r)
            2'd0: prn_nxt = capped;
            2'd1: prd_nxt = capped;
            2'd2: pbn_nxt = capped;
            2'd3: pbd_nxt = capped;
          endcase
          ph_nxt    = ph_r + 2'd1;
          state_nxt = S_PSTEP;
          if (ph_r == 2'd3) begin
            pi_nxt = pi_r + 4'd1;
            if (pi_r == 4'(POW_BITS - 1)) state_nxt = S_PEND;
          end
        end else begin
          unique case (ph_r)
            2'd0: xa_nxt = acc_r;
            2'd1: begin
              if ((f_r == FN_MUL) || (f_r == FN_DIV)) xb_nxt = acc_r;
              else xc_nxt = acc_r;
            end
            2'd2, 2'd3: xb_nxt = acc_r;
          endcase
          ph_nxt    = ph_r + 2'd1;
          state_nxt = S_MSTART;
          priority if (((f_r == FN_ADD) || (f_r == FN_SUB)) && (ph_r == 2'd2)) begin
            state_nxt = S_ADD;
          end else if ((f_r >= FN_EQ) && (ph_r == 2'd1)) begin
            state_nxt = S_CMP;
          end else if (((f_r == FN_MUL) || (f_r == FN_DIV)) && (ph_r == 2'd1)) begin
            neg_nxt   = sa ^ sb;
            state_nxt = S_FIN;
          end else begin
          end
        end
      end

      S_ADD: begin
        alu_a  = xa_r;
        alu_b  = xc_r;
        alu_op = (sa == s2) ? ALU_ADD : ALU_SUB;
        neg_nxt = sa;
        if ((sa == s2) || alu_flags.carry) begin
          xa_nxt    = alu_sum;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_ADD2;
        end
      end

      S_ADD2: begin
        alu_a     = xc_r;
        alu_b     = xa_r;
        alu_op    = ALU_SUB;
        xa_nxt    = alu_sum;
        neg_nxt   = s2;
        state_nxt = S_FIN;
      end

      S_CMP: begin
        alu_a      = xa_r;
        alu_b      = xc_r;
        alu_op     = ALU_SUB;
        em_num_nxt = '0;
        em_den_nxt = DEN_BITS'(1);
        em_cmp_nxt = t_cmp;
        em_st_nxt  = ST_OK;
        state_nxt  = S_EMIT;
      end

      S_FIN: begin
        if (xa_r == '0) begin
          em_num_nxt = '0;
          em_den_nxt = DEN_BITS'(1);
          em_cmp_nxt = 1'b0;
          em_st_nxt  = ST_OK;
          state_nxt  = S_EMIT;
        end else begin
          ga_nxt    = xa_r;
          gb_nxt    = xb_r;
          k_nxt     = '0;
          state_nxt = S_GSH;
        end
      end

      // Strip common factors of two.
      S_GSH: begin
        if (ga_r[0] || gb_r[0]) begin
          state_nxt = S_GA;
        end else begin
          ga_nxt = {1'b0, ga_r[WIDE_BITS-1:1]};
          gb_nxt = {1'b0, gb_r[WIDE_BITS-1:1]};
          k_nxt  = k_r + 7'd1;
        end
      end

      S_GA: begin
        if (ga_r[0]) state_nxt = S_GB;
        else ga_nxt = {1'b0, ga_r[WIDE_BITS-1:1]};
      end

      S_GB: begin
        if (gb_r[0]) state_nxt = S_GC1;
        else gb_nxt = {1'b0, gb_r[WIDE_BITS-1:1]};
      end

      // Keep the smaller value in ga.
      S_GC1: begin
        alu_a  = gb_r;
        alu_b  = ga_r;
        alu_op = ALU_SUB;
        if (!alu_flags.carry) begin
          ga_nxt = gb_r;
          gb_nxt = ga_r;
        end
        state_nxt = S_GC2;
      end

      S_GC2: begin
        alu_a     = gb_r;
        alu_b     = ga_r;
        alu_op    = ALU_SUB;
        gb_nxt    = alu_sum;
        state_nxt = alu_flags.zero ? S_GK : S_GB;
      end

      // Restore the common power of two, then divide both terms by the gcd.
      S_GK: begin
        if (k_r == '0) begin
          dv_nxt    = xa_r;
          rm_nxt    = '0;
          cnt_nxt   = '0;
          dph_nxt   = 1'b0;
          state_nxt = S_DIV;
        end else begin
          ga_nxt = {ga_r[WIDE_BITS-2:0], 1'b0};
          k_nxt  = k_r - 7'd1;
        end
      end

      S_DIV: begin
        alu_a   = rm_sh;
        alu_b   = ga_r;
        alu_op  = ALU_SUB;
        rm_nxt  = alu_flags.carry ? alu_sum : rm_sh;
        dv_nxt  = {dv_r[WIDE_BITS-2:0], alu_flags.carry};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(DIV_STEPS - 1)) state_nxt = S_DDONE;
      end

      S_DDONE: begin
        if (!dph_r) begin
          xa_nxt    = dv_r;
          dv_nxt    = xb_r;
          rm_nxt    = '0;
          cnt_nxt   = '0;
          dph_nxt   = 1'b1;
          state_nxt = S_DIV;
        end else begin
          xb_nxt = dv_r;
          if (f_r == FN_POW) begin
            pbn_nxt   = xa_r[63:0];
            pbd_nxt   = dv_r[63:0];
            prn_nxt   = 64'd1;
            prd_nxt   = 64'd1;
            pi_nxt    = '0;
            ph_nxt    = 2'd0;
            neg_nxt   = sa && expo[0];
            state_nxt = S_PSTEP;
          end else begin
            state_nxt = S_RANGE;
          end
        end
      end

      S_RANGE: begin
        em_cmp_nxt = 1'b0;
        if (ovf) begin
          em_num_nxt = '0;
          em_den_nxt = DEN_BITS'(1);
          em_st_nxt  = ST_OVERFLOW;
        end else begin
          em_num_nxt = neg_r ? (64'd0 - xa_r[63:0]) : xa_r[63:0];
          em_den_nxt = xb_r[DEN_BITS-1:0];
          em_st_nxt  = ST_OK;
        end
        state_nxt = S_EMIT;
      end

      // Skip the multiply into the result when this exponent bit is clear.
      S_PSTEP: begin
        if ((ph_r == 2'd0) && !expo[pi_r]) ph_nxt = 2'd2;
        else state_nxt = S_MSTART;
      end

      S_PEND: begin
        em_cmp_nxt = 1'b0;
        if ((prn_r > plim) || (prd_r > NUM_MAX)) begin
          em_num_nxt = '0;
          em_den_nxt = DEN_BITS'(1);
          em_st_nxt  = ST_OVERFLOW;
        end else begin
          em_num_nxt = neg_r ? (64'd0 - prn_r) : prn_r;
          em_den_nxt = prd_r[DEN_BITS-1:0];
          em_st_nxt  = ST_OK;
        end
        state_nxt = S_EMIT;
      end

      // Hold the result until the output register is free.
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_num_nxt   = em_num_r;
          out_den_nxt   = em_den_r;
          out_cmp_nxt   = em_cmp_r;
          out_st_nxt    = em_st_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_r <= f_nxt; an_r <= an_nxt; ad_r <= ad_nxt; bn_r <= bn_nxt; bd_r <= bd_nxt;
    xa_r <= xa_nxt; xb_r <= xb_nxt; xc_r <= xc_nxt;
    acc_r <= acc_nxt; mc_r <= mc_nxt; mp_r <= mp_nxt;
    ga_r <= ga_nxt; gb_r <= gb_nxt; dv_r <= dv_nxt; rm_r <= rm_nxt;
    cnt_r <= cnt_nxt; k_r <= k_nxt; ph_r <= ph_nxt; dph_r <= dph_nxt; neg_r <= neg_nxt;
    pi_r <= pi_nxt; prn_r <= prn_nxt; prd_r <= prd_nxt; pbn_r <= pbn_nxt;
    pbd_r <= pbd_nxt;
    em_num_r <= em_num_nxt; em_den_r <= em_den_nxt; em_cmp_r <= em_cmp_nxt;
    em_st_r <= em_st_nxt;
    out_num_r <= out_num_nxt; out_den_r <= out_den_nxt; out_cmp_r <= out_cmp_nxt;
    out_st_r <= out_st_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cmp_r, out_den_r, out_num_r};
  assign out_tuser  = out_st_r;

endmodule
`default_nettype wire

FILE: design/rau_checker.sv
// Port-level checker of the rational arithmetic unit, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module rau_checker import rau_pkg::*; (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic [255:0] in_tdata,
  input wire logic [3:0]   in_tuser,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [127:0] out_tdata,
  input wire logic [1:0]   out_tuser
);

  logic zero_frac;
  assign zero_frac = (out_tdata[63:0] == 64'd0) && (out_tdata[126:64] == 63'd1);

  // A stalled result holds.
  `ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  // One request at a time: no accept right after an accept.
  `ASSERT_NEXT(a_one_busy, in_tvalid && in_tready, !in_tready, "request taken while busy")
  // An error status always comes with 0/1 and a clear compare flag.
  `ASSERT_IMPL(a_err_zero, out_tvalid && (out_tuser != ST_OK), zero_frac && !out_tdata[127], "error result not 0/1")
  // A true compare comes with 0/1 and an ok status.
  `ASSERT_IMPL(a_cmp_zero, out_tvalid && out_tdata[127], zero_frac && (out_tuser == ST_OK), "compare result not 0/1")
  // The denominator shown is never zero.
  `ASSERT_IMPL(a_den_pos, out_tvalid, out_tdata[126:64] != 63'd0, "zero denominator shown")

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);
`default_nettype wire

FILE: verif/testbench.sv
// Testbench for the rational arithmetic unit: directed and random requests checked against a model.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import rau_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [255:0] in_tdata;   // a_num, a_den, b_num, b_den, zero pad
  logic [3:0]   in_tuser;   // func
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;  // res_num, res_den, compare_true
  logic [1:0]   out_tuser;  // status

  typedef struct {
    logic [63:0] num;
    logic [62:0] den;
    logic        cmp;
    logic [1:0]  st;
  } answer_t;

  answer_t answer_q[$];
  int      fail_count;
  longint  cycle_count = 0;
  int      sent_count;
  int      got_count;
  bit      idle_on;
  bit      hold_req;
  bit      hold_long;
  int      stall_left;
  localparam longint CYCLE_LIMIT = 64'd40_000_000;

  rational_arithmetic_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // ---------------------------------------------------------------- model
  function automatic logic [127:0] gcd_wide(logic [127:0] x, logic [127:0] y);
    logic [127:0] t;
    while (y != 0) begin
      t = x % y; x = y; y = t;
    end
    return x;
  endfunction

  function automatic logic [63:0] mag(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  // Reduce a sign-magnitude fraction and range check it.
  function automatic answer_t reduce_frac(bit neg, logic [127:0] n, logic [127:0] d);
    answer_t r;
    logic [127:0] g;
    logic [127:0] lim;
    r = '{64'd0, 63'd1, 1'b0, ST_OK};
    if (n == 0) return r;
    g = gcd_wide(n, d);
    n = n / g;
    d = d / g;
    lim = neg ? {64'd0, NUM_MAX} + 1 : {64'd0, NUM_MAX};
    if (n > lim || d > {64'd0, NUM_MAX}) begin
      r.st = ST_OVERFLOW;
      return r;
    end
    r.num = neg ? -n[63:0] : n[63:0];
    r.den = d[62:0];
    return r;
  endfunction

  function automatic logic [63:0] cap_mul(logic [63:0] x, logic [63:0] y, logic [63:0] lim);
    logic [127:0] p;
    p = x * y;
    return (p > {64'd0, lim}) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
  endfunction

  function automatic answer_t power_of(logic [63:0] an, logic [62:0] ad, logic [15:0] e);
    answer_t r;
    bit neg;
    logic [63:0] n, d, g, lim, rn, rd, bn, bd;
    r = '{64'd0, 63'd1, 1'b0, ST_OK};
    n = mag(an);
    if (n == 0) begin
      if (e == 0) r.num = 64'd1;
      return r;
    end
    d = {1'b0, ad};
    g = 64'(gcd_wide({64'd0, n}, {64'd0, d}));
    n = n / g;
    d = d / g;
    neg = an[63] && e[0];
    lim = neg ? NUM_MAX + 64'd1 : NUM_MAX;
    rn = 64'd1; rd = 64'd1; bn = n; bd = d;
    for (int i = 0; i < 16; i++) begin
      if (e[i]) begin
        rn = cap_mul(rn, bn, lim);
        rd = cap_mul(rd, bd, NUM_MAX);
      end
      bn = cap_mul(bn, bn, lim);
      bd = cap_mul(bd, bd, NUM_MAX);
    end
    if (rn > lim || rd > NUM_MAX) begin
      r.st = ST_OVERFLOW;
      return r;
    end
    r.num = neg ? -rn : rn;
    r.den = rd[62:0];
    return r;
  endfunction

  function automatic answer_t rational_result(logic [3:0] fn, logic [63:0] an,
                                              logic [62:0] ad, logic [63:0] bn,
                                              logic [62:0] bd);
    answer_t r;
    bit sa, sb, s2, uses_b;
    logic [127:0] t1, t2, dd;
    logic signed [191:0] lhs, rhs;
    r = '{64'd0, 63'd1, 1'b0, ST_OK};
    sa = an[63];
    sb = bn[63];
    uses_b = (fn != FN_NEG && fn != FN_POW);
    if (fn > FN_GE) return r;
    if (ad == 0 || (uses_b && bd == 0)) begin
      r.st = ST_DIV_ZERO;
      return r;
    end
    t1 = mag(an) * {1'b0, bd};
    t2 = mag(bn) * {1'b0, ad};
    dd = {1'b0, ad} * {1'b0, bd};
    case (fn)
      FN_ADD, FN_SUB: begin
        s2 = (fn == FN_SUB) ? !sb : sb;
        if (sa == s2) r = reduce_frac(sa, t1 + t2, dd);
        else if (t1 >= t2) r = reduce_frac(sa, t1 - t2, dd);
        else r = reduce_frac(s2, t2 - t1, dd);
      end
      FN_MUL: r = reduce_frac(sa != sb, mag(an) * mag(bn), dd);
      FN_DIV: begin
        if (bn == 0) r.st = ST_DIV_ZERO;
        else r = reduce_frac(sa != sb, t1, {1'b0, ad} * mag(bn));
      end
      FN_NEG: r = reduce_frac(!sa, {64'd0, mag(an)}, {65'd0, ad});
      FN_POW: r = power_of(an, ad, bn[15:0]);
      default: begin
        // compare a_num*b_den against b_num*a_den, both signed and exact
        lhs = $signed(an) * $signed({129'd0, bd});
        rhs = $signed(bn) * $signed({129'd0, ad});
        case (fn)
          FN_EQ: r.cmp = (lhs == rhs);
          FN_NE: r.cmp = (lhs != rhs);
          FN_LT: r.cmp = (lhs < rhs);
          FN_LE: r.cmp = (lhs <= rhs);
          FN_GT: r.cmp = (lhs > rhs);
          default: r.cmp = (lhs >= rhs);
        endcase
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- driver
  // Valid stays up after an accept until the next request or an idle gap
  // replaces it, so in_tvalid never gets two updates in one time step.
  task automatic send_request(logic [3:0] fn, logic [63:0] an, logic [62:0] ad,
                              logic [63:0] bn, logic [62:0] bd);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {2'b00, bd, bn, ad, an};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    answer_q.push_back(rational_result(fn, an, ad, bn, bd));
    sent_count++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_num();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(0, 20)) - 64'd10;
      2: return {{32{1'b0}}, $urandom};
      3: return -{{32{1'b0}}, $urandom};
      4: return {{48{1'b0}}, 16'($urandom)};
      default: return 64'($signed(20'($urandom)));
    endcase
  endfunction

  function automatic logic [62:0] rand_den();
    logic [62:0] d;
    case ($urandom_range(0, 4))
      0: d = 63'({$urandom, $urandom});
      1: d = 63'($urandom_range(1, 12));
      2: d = {{31{1'b0}}, $urandom};
      default: d = {{47{1'b0}}, 16'($urandom)};
    endcase
    return (d == 0) ? 63'd1 : d;
  endfunction

  // ---------------------------------------------------------------- tests
  localparam logic [63:0] MIN_NUM = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_NUM = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [62:0] MAX_DEN = 63'h7FFF_FFFF_FFFF_FFFF;

  task automatic test_every_function();
    for (int f = 0; f < 16; f++) send_request(f[3:0], 64'd3, 63'd4, -64'd5, 63'd6);
  endtask

  task automatic test_special_cases();
    send_request(FN_ADD, MAX_NUM, 63'd1, MAX_NUM, 63'd1);      // overflow
    send_request(FN_SUB, MIN_NUM, 63'd1, 64'd1, 63'd1);        // overflow below min
    send_request(FN_NEG, MIN_NUM, 63'd1, 64'd0, 63'd0);        // -min overflows
    send_request(FN_MUL, MIN_NUM, MAX_DEN, MAX_NUM, MAX_DEN);
    send_request(FN_DIV, 64'd7, 63'd3, 64'd0, 63'd5);          // divide by zero
    send_request(FN_ADD, 64'd1, 63'd0, 64'd1, 63'd1);          // zero denominator
    send_request(FN_EQ, 64'd1, 63'd2, 64'd1, 63'd0);           // zero b denominator
    send_request(FN_POW, 64'd0, 63'd5, 64'd0, 63'd0);          // 0^0
    send_request(FN_POW, -64'd6, 63'd4, 64'h1234_0000_0000_0003, 63'd1);
    send_request(FN_POW, 64'd2, 63'd1, 64'h0000_0000_0000_FFFF, 63'd1);
    send_request(FN_POW, -64'd2, 63'd1, 64'd63, 63'd1);        // exactly min
    send_request(FN_EQ, 64'd2, 63'd4, 64'd1, 63'd2);           // unreduced equal
    send_request(FN_LE, MIN_NUM, MAX_DEN, -64'd1, 63'd1);
    send_request(FN_GE, MAX_NUM, 63'd1, MAX_NUM, MAX_DEN);
    send_request(FN_ADD, 64'd0, MAX_DEN, 64'd0, 63'd1);        // zero result
    drain_results();
  endtask

  task automatic test_random(int count);
    logic [3:0] fn;
    for (int i = 0; i < count; i++) begin
      fn = ($urandom_range(0, 40) == 0) ? 4'($urandom_range(12, 15))
                                        : 4'($urandom_range(0, 11));
      // shrink exponents mostly, so pow does not saturate every time
      send_request(fn, (fn == FN_POW && $urandom_range(0, 1)) ?
                       64'($urandom_range(0, 9)) - 64'd4 : rand_num(),
                   ($urandom_range(0, 60) == 0) ? 63'd0 : rand_den(),
                   (fn == FN_POW && $urandom_range(0, 2) != 0) ?
                       {$urandom, 16'd0, 16'($urandom_range(0, 40))} : rand_num(),
                   ($urandom_range(0, 60) == 0) ? 63'd0 : rand_den());
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 4; i++) send_request(FN_MUL, rand_num(), rand_den(),
                                             rand_num(), rand_den());
    hold_req = 1'b0;
    drain_results();
  endtask

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (hold_long) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Hold the receiver off for a counted stretch once a hold is requested.
  initial begin
    int held;
    held = 0;
    hold_long = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && held < 3000) begin
        hold_long = 1'b1;
        held++;
      end else begin
        hold_long = 1'b0;
        if (!hold_req) held = 0;
      end
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got_count++;
      if (answer_q.size() == 0) begin
        $error("result with no request waiting");
        fail_count++;
      end else begin
        want = answer_q.pop_front();
        if (out_tdata[63:0] !== want.num) begin
          $error("res_num expected %0d got %0d", $signed(want.num),
                 $signed(out_tdata[63:0]));
          fail_count++;
        end
        if (out_tdata[126:64] !== want.den) begin
          $error("res_den expected %0d got %0d", want.den, out_tdata[126:64]);
          fail_count++;
        end
        if (out_tdata[127] !== want.cmp) begin
          $error("compare_true expected %0d got %0d", want.cmp, out_tdata[127]);
          fail_count++;
        end
        if (out_tuser !== want.st) begin
          $error("status expected %0d got %0d", want.st, out_tuser);
          fail_count++;
        end
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    fail_count = 0; sent_count = 0; got_count = 0;
    idle_on = 1'b1; hold_req = 1'b0;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_every_function();
    test_special_cases();
    test_backpressure();
    test_random(1300);
    drain_results();
    idle_on = 1'b0;
    test_random(250);
    drain_results();
    repeat (50) @(posedge clk);
    if (answer_q.size() != 0) begin
      $error("results missing: %0d", answer_q.size());
      fail_count++;
    end
    $display("Covered %0d requests and %0d results across all codes,", sent_count, got_count);
    $display("edge operands, stalls and a long output hold.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
